### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the pedestal statistics rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define PSA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define PSA_NEVER(lbl, clk, rst_n, cond, msg) \
    `PSA_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

### hdl/psa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psa_pkg
// types, widths and codes shared by the pedestal statistics accumulator
// ---------------------------------------------------------------------------
package psa_pkg;

    // geometry
    localparam int MODULES           = 32;
    localparam int CHIPS             = 16;
    localparam int CHANNELS_PER_CHIP = 18;
    localparam int COUNT_BITS        = 20;
    localparam int CELL_COUNT        = MODULES * CHIPS * CHANNELS_PER_CHIP;
    localparam int CELL_BITS         = $clog2(CELL_COUNT);

    // field widths
    localparam int CMD_BITS  = 2;
    localparam int MOD_BITS  = 5;
    localparam int CHIP_BITS = 4;
    localparam int CHAN_BITS = 5;
    localparam int ADC_BITS  = 16;
    localparam int Q_BITS    = 24;
    localparam int FRAC_BITS = 8;

    // arithmetic widths
    localparam int SUM_BITS    = ADC_BITS + COUNT_BITS;
    localparam int SQ_BITS     = 2 * ADC_BITS + COUNT_BITS;
    localparam int PROD_BITS   = 2 * SUM_BITS;
    localparam int RAD_SHIFT   = 2 * FRAC_BITS;
    localparam int RAD_BITS    = PROD_BITS + RAD_SHIFT;
    localparam int ROOT_BITS   = RAD_BITS / 2;
    localparam int QUOT_BITS   = SUM_BITS + FRAC_BITS;
    localparam int ITER_BITS   = $clog2(QUOT_BITS + 1);

    // shared multiplier, one operand cut into digits
    localparam int MUL_B_BITS  = 16;
    localparam int MPROD_BITS  = SUM_BITS + MUL_B_BITS;
    localparam int SQ_CHUNKS   = (SQ_BITS + MUL_B_BITS - 1) / MUL_B_BITS;
    localparam int S_CHUNKS    = (SUM_BITS + MUL_B_BITS - 1) / MUL_B_BITS;
    localparam int MUL_STEPS   = SQ_CHUNKS + S_CHUNKS;
    localparam int MSTEP_BITS  = $clog2(MUL_STEPS + 1);

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_BITS-1:0] VALID_RESET = COUNT_BITS'(450);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ACC   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_SPARE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_ACC   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_ZERO  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [CELL_BITS-1:0] cell_idx;
        logic [ADC_BITS-1:0]  adc;
    } t_entry;

    typedef struct packed {
        logic [SUM_BITS-1:0]   sum;
        logic [SQ_BITS-1:0]    sq;
        logic [COUNT_BITS-1:0] cnt;
    } t_stats;

    typedef struct packed {
        logic [Q_BITS-1:0] mean;
        logic [Q_BITS-1:0] err;
    } t_res;

    typedef struct packed {
        logic [Q_BITS-1:0]     mean;
        logic [Q_BITS-1:0]     err;
        logic [COUNT_BITS-1:0] count;
        logic                  valid;
        logic                  sat;
    } t_result;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

endpackage

### hdl/psa_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psa_front
// input word decode: command class, cell number and range check
// ---------------------------------------------------------------------------
module psa_front (
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [psa_pkg::CMD_BITS-1:0]    i_command,
    input  logic [psa_pkg::MOD_BITS-1:0]    i_module_index,
    input  logic [psa_pkg::CHIP_BITS-1:0]   i_chip_index,
    input  logic [psa_pkg::CHAN_BITS-1:0]   i_channel_index,
    input  logic [psa_pkg::ADC_BITS-1:0]    i_adc_value,
    input  psa_pkg::t_back_status           i_status,
    input  logic                            i_q_full,
    output logic                            o_push,
    output psa_pkg::t_entry                 o_entry
);

    logic                           w_in_range;
    logic [psa_pkg::CELL_BITS-1:0]  w_row;

    assign w_in_range = (int'(i_module_index) < psa_pkg::MODULES)
                     && (int'(i_chip_index) < psa_pkg::CHIPS)
                     && (int'(i_channel_index) < psa_pkg::CHANNELS_PER_CHIP);

    assign w_row = psa_pkg::CELL_BITS'(i_module_index) * psa_pkg::CELL_BITS'(psa_pkg::CHIPS)
                 + psa_pkg::CELL_BITS'(i_chip_index);

    assign o_s_tready = !i_q_full && !i_status.init_busy;
    assign o_push     = i_s_tvalid && o_s_tready;

    always_comb begin
        o_entry.adc      = i_adc_value;
        o_entry.cell_idx = w_row * psa_pkg::CELL_BITS'(psa_pkg::CHANNELS_PER_CHIP)
                         + psa_pkg::CELL_BITS'(i_channel_index);
        unique case (i_command)
            psa_pkg::CMD_ACC:   o_entry.op = w_in_range ? psa_pkg::OP_ACC : psa_pkg::OP_ZERO;
            psa_pkg::CMD_READ:  o_entry.op = w_in_range ? psa_pkg::OP_READ : psa_pkg::OP_ZERO;
            psa_pkg::CMD_CLEAR: o_entry.op = psa_pkg::OP_CLEAR;
            default:            o_entry.op = psa_pkg::OP_ZERO;
        endcase
    end

endmodule

### hdl/psa_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psa_queue
// short command queue between decode and execution
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module psa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  psa_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output psa_pkg::t_entry o_entry
);

    psa_pkg::t_entry                r_mem [psa_pkg::QUEUE_DEPTH];
    logic [psa_pkg::QPTR_BITS-1:0]  r_wr_ptr;
    logic [psa_pkg::QPTR_BITS-1:0]  r_rd_ptr;
    logic [psa_pkg::QCNT_BITS-1:0]  r_count;

    assign o_full  = (r_count == psa_pkg::QCNT_BITS'(psa_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == psa_pkg::QPTR_BITS'(psa_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == psa_pkg::QPTR_BITS'(psa_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    `PSA_NEVER(a_q_no_overflow, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `PSA_NEVER(a_q_no_underflow, i_clk, i_rst_n, i_pop && !o_valid, "pop from empty queue")

endmodule

### hdl/psa_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psa_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module psa_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [psa_pkg::QUOT_BITS-1:0]   i_dividend,
    input  logic [psa_pkg::COUNT_BITS-1:0]  i_divisor,
    output logic                            o_busy,
    output logic [psa_pkg::QUOT_BITS-1:0]   o_quot
);

    logic [psa_pkg::ITER_BITS-1:0]  r_cnt;
    logic [psa_pkg::QUOT_BITS-1:0]  r_quot;
    logic [psa_pkg::COUNT_BITS-1:0] r_rem;
    logic [psa_pkg::COUNT_BITS-1:0] r_dvr;
    logic [psa_pkg::COUNT_BITS:0]   w_trial;
    logic [psa_pkg::COUNT_BITS:0]   w_diff;
    logic                           w_ge;

    assign w_trial = {r_rem, r_quot[psa_pkg::QUOT_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_dvr};
    assign w_ge    = (w_trial >= {1'b0, r_dvr});
    assign o_busy  = (r_cnt != '0);
    assign o_quot  = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= psa_pkg::ITER_BITS'(psa_pkg::QUOT_BITS);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvr  <= i_divisor;
        end else if (o_busy) begin
            r_rem  <= w_ge ? w_diff[psa_pkg::COUNT_BITS-1:0]
                           : w_trial[psa_pkg::COUNT_BITS-1:0];
            r_quot <= {r_quot[psa_pkg::QUOT_BITS-2:0], w_ge};
        end
    end

    `PSA_NEVER(a_div_no_restart, i_clk, i_rst_n, i_start && o_busy, "divider restarted while busy")

endmodule

### hdl/psa_sqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psa_sqrt
// digit-by-digit integer square root, one root bit per cycle
// ---------------------------------------------------------------------------
module psa_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [psa_pkg::RAD_BITS-1:0]    i_rad,
    output logic                            o_busy,
    output logic [psa_pkg::ROOT_BITS-1:0]   o_root
);

    localparam int REM_BITS = psa_pkg::ROOT_BITS + 2;

    logic [psa_pkg::ITER_BITS-1:0]  r_cnt;
    logic [psa_pkg::RAD_BITS-1:0]   r_rad;
    logic [REM_BITS-1:0]            r_rem;
    logic [psa_pkg::ROOT_BITS-1:0]  r_root;
    logic [REM_BITS-1:0]            w_rem_sh;
    logic [REM_BITS-1:0]            w_trial;
    logic                           w_ge;

    // bring down the next two radicand bits, try root*4+1
    assign w_rem_sh = {r_rem[REM_BITS-3:0], r_rad[psa_pkg::RAD_BITS-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);
    assign o_busy   = (r_cnt != '0);
    assign o_root   = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= psa_pkg::ITER_BITS'(psa_pkg::ROOT_BITS);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (o_busy) begin
            r_rad  <= {r_rad[psa_pkg::RAD_BITS-3:0], 2'b00};
            r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[psa_pkg::ROOT_BITS-2:0], w_ge};
        end
    end

endmodule

### hdl/psa_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psa_back
// execution side: cell memories, update sequencer, shared arithmetic
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module psa_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [psa_pkg::COUNT_BITS-1:0]  i_cfg_wr_data,
    input  logic                            i_q_valid,
    input  psa_pkg::t_entry                 i_q_entry,
    output logic                            o_q_pop,
    output psa_pkg::t_back_status           o_status,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output psa_pkg::t_result                o_result
);

    typedef enum logic [8:0] {
        ST_INIT  = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_LOAD  = 9'b000000100,
        ST_SQADD = 9'b000001000,
        ST_MUL   = 9'b000010000,
        ST_DIFF  = 9'b000100000,
        ST_SQRT  = 9'b001000000,
        ST_EDIV  = 9'b010000000,
        ST_CLEAR = 9'b100000000
    } t_state;

    localparam int SQ_PAD_BITS = psa_pkg::SQ_CHUNKS * psa_pkg::MUL_B_BITS;
    localparam int S_PAD_BITS  = psa_pkg::S_CHUNKS * psa_pkg::MUL_B_BITS;

    // cell memories
    psa_pkg::t_stats r_stats_mem [psa_pkg::CELL_COUNT];
    psa_pkg::t_res   r_res_mem   [psa_pkg::CELL_COUNT];
    psa_pkg::t_stats r_stats_q;
    psa_pkg::t_res   r_res_q;

    t_state                             r_state,     n_state;
    logic [psa_pkg::CELL_BITS-1:0]      r_sweep,     n_sweep;
    logic [psa_pkg::CELL_BITS-1:0]      r_cell,      n_cell;
    logic [psa_pkg::ADC_BITS-1:0]       r_adc,       n_adc;
    psa_pkg::t_op                       r_op,        n_op;
    logic [psa_pkg::COUNT_BITS-1:0]     r_n,         n_n;
    logic [psa_pkg::SUM_BITS-1:0]       r_s,         n_s;
    logic [psa_pkg::SQ_BITS-1:0]        r_sq,        n_sq;
    logic [psa_pkg::Q_BITS-1:0]         r_mean,      n_mean;
    logic [psa_pkg::MPROD_BITS-1:0]     r_mprod,     n_mprod;
    logic                               r_mv,        n_mv;
    logic                               r_mdst_b,    n_mdst_b;
    logic [psa_pkg::MSTEP_BITS-1:0]     r_mstep,     n_mstep;
    logic [psa_pkg::PROD_BITS-1:0]      r_acc_a,     n_acc_a;
    logic [psa_pkg::PROD_BITS-1:0]      r_acc_b,     n_acc_b;
    logic                               r_out_valid, n_out_valid;
    psa_pkg::t_result                   r_out,       n_out;
    logic [psa_pkg::COUNT_BITS-1:0]     r_min_valid;

    logic                               w_st_we;
    logic                               w_res_we;
    logic [psa_pkg::CELL_BITS-1:0]      w_waddr;
    psa_pkg::t_stats                    w_st_wdata;
    psa_pkg::t_res                      w_res_wdata;
    logic [psa_pkg::SUM_BITS-1:0]       w_ma;
    logic [psa_pkg::MUL_B_BITS-1:0]     w_mb;
    logic [psa_pkg::MPROD_BITS-1:0]     w_mult;
    logic [SQ_PAD_BITS-1:0]             w_sq_pad;
    logic [S_PAD_BITS-1:0]              w_s_pad;
    logic [psa_pkg::PROD_BITS-1:0]      w_diff;
    logic                               w_div_start;
    logic [psa_pkg::QUOT_BITS-1:0]      w_div_dvd;
    logic                               w_div_busy;
    logic [psa_pkg::QUOT_BITS-1:0]      w_div_q;
    logic                               w_sqrt_start;
    logic [psa_pkg::RAD_BITS-1:0]       w_sqrt_rad;
    logic                               w_sqrt_busy;
    logic [psa_pkg::ROOT_BITS-1:0]      w_sqrt_root;
    logic [psa_pkg::Q_BITS-1:0]         w_err_sat;

    function automatic logic [psa_pkg::Q_BITS-1:0] f_sat(
        input logic [psa_pkg::QUOT_BITS-1:0] q
    );
        if (|q[psa_pkg::QUOT_BITS-1:psa_pkg::Q_BITS]) begin
            return '1;
        end
        return q[psa_pkg::Q_BITS-1:0];
    endfunction

    psa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (r_n),
        .o_busy     (w_div_busy),
        .o_quot     (w_div_q)
    );

    psa_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_rad   (w_sqrt_rad),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_sqrt_root)
    );

    assign w_mult     = psa_pkg::MPROD_BITS'(w_ma) * psa_pkg::MPROD_BITS'(w_mb);
    assign w_sq_pad   = SQ_PAD_BITS'(r_sq);
    assign w_s_pad    = S_PAD_BITS'(r_s);
    assign w_diff     = (r_acc_a >= r_acc_b) ? (r_acc_a - r_acc_b) : '0;
    assign w_sqrt_rad = {w_diff, psa_pkg::RAD_SHIFT'(0)};
    assign w_err_sat  = f_sat(w_div_q);

    assign o_status.init_busy = (r_state == ST_INIT);
    assign o_m_tvalid         = r_out_valid;
    assign o_result           = r_out;

    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_cell      = r_cell;
        n_adc       = r_adc;
        n_op        = r_op;
        n_n         = r_n;
        n_s         = r_s;
        n_sq        = r_sq;
        n_mean      = r_mean;
        n_mprod     = r_mprod;
        n_mv        = 1'b0;
        n_mdst_b    = r_mdst_b;
        n_mstep     = r_mstep;
        n_acc_a     = r_acc_a;
        n_acc_b     = r_acc_b;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        w_st_we     = 1'b0;
        w_res_we    = 1'b0;
        w_waddr     = r_cell;
        w_st_wdata  = '{sum: r_s, sq: r_sq, cnt: r_n};
        w_res_wdata = '{mean: r_mean, err: w_err_sat};
        w_ma        = '0;
        w_mb        = '0;
        w_div_start = 1'b0;
        w_div_dvd   = {r_s, psa_pkg::FRAC_BITS'(0)};
        w_sqrt_start = 1'b0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_INIT: begin
                w_st_we     = 1'b1;
                w_res_we    = 1'b1;
                w_waddr     = r_sweep;
                w_st_wdata  = '0;
                w_res_wdata = '0;
                n_sweep     = r_sweep + 1'b1;
                if (r_sweep == psa_pkg::CELL_BITS'(psa_pkg::CELL_COUNT - 1)) begin
                    n_sweep = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    o_q_pop = 1'b1;
                    n_cell  = i_q_entry.cell_idx;
                    n_adc   = i_q_entry.adc;
                    n_op    = i_q_entry.op;
                    unique case (i_q_entry.op)
                        psa_pkg::OP_ZERO: begin
                            n_out       = '0;
                            n_out_valid = 1'b1;
                        end
                        psa_pkg::OP_CLEAR: begin
                            n_sweep = '0;
                            n_state = ST_CLEAR;
                        end
                        psa_pkg::OP_ACC,
                        psa_pkg::OP_READ: begin
                            n_state = ST_LOAD;
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                n_state = ST_IDLE;
                if (r_op == psa_pkg::OP_READ || (&r_stats_q.cnt)) begin
                    // read, or a full cell that ignores the sample
                    n_out.mean  = r_res_q.mean;
                    n_out.err   = r_res_q.err;
                    n_out.count = r_stats_q.cnt;
                    n_out.valid = (r_stats_q.cnt >= r_min_valid);
                    n_out.sat   = (r_op != psa_pkg::OP_READ);
                    n_out_valid = 1'b1;
                end else begin
                    n_n     = r_stats_q.cnt + 1'b1;
                    n_s     = r_stats_q.sum + psa_pkg::SUM_BITS'(r_adc);
                    n_sq    = r_stats_q.sq;
                    w_ma    = psa_pkg::SUM_BITS'(r_adc);
                    w_mb    = psa_pkg::MUL_B_BITS'(r_adc);
                    n_mprod = w_mult;
                    n_state = ST_SQADD;
                end
            end
            ST_SQADD: begin
                n_sq        = r_sq + psa_pkg::SQ_BITS'(r_mprod);
                w_div_start = 1'b1;
                n_acc_a     = '0;
                n_acc_b     = '0;
                n_mstep     = '0;
                n_state     = ST_MUL;
            end
            ST_MUL: begin
                // most significant digit first, accumulated in the cycle after the product
                if (int'(r_mstep) < psa_pkg::MUL_STEPS) begin
                    if (int'(r_mstep) < psa_pkg::SQ_CHUNKS) begin
                        w_ma = psa_pkg::SUM_BITS'(r_n);
                        w_mb = w_sq_pad[psa_pkg::MUL_B_BITS
                               * (psa_pkg::SQ_CHUNKS - 1 - int'(r_mstep)) +: psa_pkg::MUL_B_BITS];
                    end else begin
                        w_ma = r_s;
                        w_mb = w_s_pad[psa_pkg::MUL_B_BITS
                               * (psa_pkg::MUL_STEPS - 1 - int'(r_mstep)) +: psa_pkg::MUL_B_BITS];
                    end
                    n_mprod  = w_mult;
                    n_mv     = 1'b1;
                    n_mdst_b = (int'(r_mstep) >= psa_pkg::SQ_CHUNKS);
                    n_mstep  = r_mstep + 1'b1;
                end
                if (r_mv) begin
                    if (r_mdst_b) begin
                        n_acc_b = (r_acc_b << psa_pkg::MUL_B_BITS)
                                + psa_pkg::PROD_BITS'(r_mprod);
                    end else begin
                        n_acc_a = (r_acc_a << psa_pkg::MUL_B_BITS)
                                + psa_pkg::PROD_BITS'(r_mprod);
                    end
                end
                if (int'(r_mstep) == psa_pkg::MUL_STEPS && !r_mv) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: begin
                w_sqrt_start = 1'b1;
                n_state      = ST_SQRT;
            end
            ST_SQRT: begin
                if (!w_sqrt_busy && !w_div_busy) begin
                    n_mean      = f_sat(w_div_q);
                    w_div_start = 1'b1;
                    w_div_dvd   = psa_pkg::QUOT_BITS'(w_sqrt_root);
                    n_state     = ST_EDIV;
                end
            end
            ST_EDIV: begin
                if (!w_div_busy) begin
                    w_st_we     = 1'b1;
                    w_res_we    = 1'b1;
                    n_out.mean  = r_mean;
                    n_out.err   = w_err_sat;
                    n_out.count = r_n;
                    n_out.valid = (r_n >= r_min_valid);
                    n_out.sat   = 1'b0;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                // sums and counts only, stored mean and error stay
                w_st_we    = 1'b1;
                w_waddr    = r_sweep;
                w_st_wdata = '0;
                n_sweep    = r_sweep + 1'b1;
                if (r_sweep == psa_pkg::CELL_BITS'(psa_pkg::CELL_COUNT - 1)) begin
                    n_sweep     = '0;
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
            r_mv        <= 1'b0;
            r_mstep     <= '0;
            r_min_valid <= psa_pkg::VALID_RESET;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
            r_mv        <= n_mv;
            r_mstep     <= n_mstep;
            if (i_cfg_wr_en) begin
                r_min_valid <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell   <= n_cell;
        r_adc    <= n_adc;
        r_op     <= n_op;
        r_n      <= n_n;
        r_s      <= n_s;
        r_sq     <= n_sq;
        r_mean   <= n_mean;
        r_mprod  <= n_mprod;
        r_mdst_b <= n_mdst_b;
        r_acc_a  <= n_acc_a;
        r_acc_b  <= n_acc_b;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_st_we) begin
            r_stats_mem[w_waddr] <= w_st_wdata;
        end
        if (o_q_pop) begin
            r_stats_q <= r_stats_mem[i_q_entry.cell_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_we) begin
            r_res_mem[w_waddr] <= w_res_wdata;
        end
        if (o_q_pop) begin
            r_res_q <= r_res_mem[i_q_entry.cell_idx];
        end
    end

    `PSA_NEVER(a_init_quiet, i_clk, i_rst_n, (r_state == ST_INIT) && r_out_valid, "word out during init sweep")
    `PSA_NEVER(a_sqrt_free, i_clk, i_rst_n, w_sqrt_start && w_sqrt_busy, "root unit restarted while busy")

endmodule

### hdl/pedestal_statistics_accumulator_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pedestal_statistics_accumulator_unit
// per-channel pedestal mean and standard error, one result word per command
// ---------------------------------------------------------------------------
// usage
//   slave stream carries commands: tuser is the command (accumulate, read,
//   clear all), tdata the module, chip, channel and adc sample
//   master stream returns one word per command: mean and error (Q16.8),
//   sample count, and in tuser the valid and saturated flags
//   i_cfg_wr_en/i_cfg_wr_data set the sample count needed for valid
// command sequences
//   out-of-range or unused command: all-zero word; read: stored results
//   accumulate: the 44-bit square root followed by the 44-bit error
//   division; the mean division overlaps the root
//   clear all: one cell per cycle through the sum memory
// reset
//   after reset an init sweep zeroes all 9216 cells; s_tready
//   stays low until it is done, configuration writes are still taken
// stall
//   a result waits in the output register while m_tready is low; two
//   commands queue up behind it before s_tready drops
// ---------------------------------------------------------------------------
module pedestal_statistics_accumulator_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [31:0]                     i_s_tdata,   // module_index, chip_index,
                                                          // channel_index, adc_value
    input  logic [psa_pkg::CMD_BITS-1:0]    i_s_tuser,   // command
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [71:0]                     o_m_tdata,   // mean_value, mean_error,
                                                          // sample_count
    output logic [1:0]                      o_m_tuser,   // is_valid, saturated
    // configuration
    input  logic                            i_cfg_wr_en,
    input  logic [psa_pkg::COUNT_BITS-1:0]  i_cfg_wr_data
);

    localparam int CHIP_LO = psa_pkg::MOD_BITS;
    localparam int CHAN_LO = CHIP_LO + psa_pkg::CHIP_BITS;
    localparam int ADC_LO  = CHAN_LO + psa_pkg::CHAN_BITS;
    localparam int OUT_USED = 2 * psa_pkg::Q_BITS + psa_pkg::COUNT_BITS;

    psa_pkg::t_back_status  w_status;
    psa_pkg::t_entry        w_push_entry;
    psa_pkg::t_entry        w_head;
    psa_pkg::t_result       w_result;
    logic                   w_push;
    logic                   w_pop;
    logic                   w_q_full;
    logic                   w_q_valid;

    // decode and classify
    psa_front u_front (
        .i_s_tvalid      (i_s_tvalid),
        .o_s_tready      (o_s_tready),
        .i_command       (i_s_tuser),
        .i_module_index  (i_s_tdata[psa_pkg::MOD_BITS-1:0]),
        .i_chip_index    (i_s_tdata[CHIP_LO +: psa_pkg::CHIP_BITS]),
        .i_channel_index (i_s_tdata[CHAN_LO +: psa_pkg::CHAN_BITS]),
        .i_adc_value     (i_s_tdata[ADC_LO +: psa_pkg::ADC_BITS]),
        .i_status        (w_status),
        .i_q_full        (w_q_full),
        .o_push          (w_push),
        .o_entry         (w_push_entry)
    );

    // decouples decode from the long accumulate sequence
    psa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_entry (w_head)
    );

    // cell memories and arithmetic
    psa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (w_q_valid),
        .i_q_entry     (w_head),
        .o_q_pop       (w_pop),
        .o_status      (w_status),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_result      (w_result)
    );

    // pack the result word, unused top bits zero
    assign o_m_tdata = {(72 - OUT_USED)'(0), w_result.count, w_result.err, w_result.mean};
    assign o_m_tuser = {w_result.sat, w_result.valid};

    // the two spare command-word bits are not used
    logic w_spare_unused;
    assign w_spare_unused = ^i_s_tdata[31:ADC_LO + psa_pkg::ADC_BITS];

endmodule
